### rtl/eepc_pkg.sv
// eepc_pkg: shared constants for the edge-edge proximity contact core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package eepc_pkg;
  localparam int RADIUS_BITS = 17;
  localparam int LIMB_BITS   = 27;
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 8;
endpackage
`default_nettype wire

### rtl/eepc_fifo.sv
// eepc_fifo: small register queue between pipeline parts
// no package dependency
`timescale 1ns / 1ps
`default_nettype none
module eepc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

### rtl/eepc_umul.sv
// eepc_umul: two-stage unsigned multiplier built from limb partial products
// depends on eepc_pkg for the limb width
`timescale 1ns / 1ps
`default_nettype none
module eepc_umul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic             clk,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  import eepc_pkg::*;
  localparam int L  = LIMB_BITS;
  localparam int NA = (WA + L - 1) / L;
  localparam int NB = (WB + L - 1) / L;
  localparam int PW = (NA + NB) * L;

  logic [NA*L-1:0] ax;
  logic [NB*L-1:0] bx;
  logic [2*L-1:0]  pp_r [NA*NB];
  logic [PW-1:0]   acc;
  logic [WA+WB-1:0] p_r;

  assign ax = (NA*L)'(a);
  assign bx = (NB*L)'(b);
  assign p  = p_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i*NB+j] <= (2*L)'(ax[i*L +: L]) * (2*L)'(bx[j*L +: L]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp_r[i*NB+j]) << ((i + j) * L));
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= acc[WA+WB-1:0];
  end
endmodule
`default_nettype wire

### rtl/eepc_front.sv
// eepc_front: accepts edge pairs and flags shared-vertex, box and degenerate rejects
// depends on eepc_pkg for the radius width
`timescale 1ns / 1ps
`default_nettype none
module eepc_front #(
  parameter int C  = 16,
  parameter int VB = 20
) (
  input  logic [VB-1:0]  a_v0,
  input  logic [VB-1:0]  a_v1,
  input  logic [VB-1:0]  b_v0,
  input  logic [VB-1:0]  b_v1,
  input  logic [3*C-1:0] pa0,
  input  logic [3*C-1:0] pa1,
  input  logic [3*C-1:0] pb0,
  input  logic [3*C-1:0] pb1,
  input  logic [eepc_pkg::RADIUS_BITS-1:0] radius,
  output logic [12*C:0]  item
);
  import eepc_pkg::*;
  localparam int EW = ((C > RADIUS_BITS) ? C : RADIUS_BITS) + 2;

  logic              shared, degen;
  logic [2:0]        sep;
  logic signed [EW-1:0] dr;

  assign dr = EW'($signed({1'b0, radius}));
  assign shared = (a_v0 == b_v0) || (a_v0 == b_v1) || (a_v1 == b_v0) || (a_v1 == b_v1);
  assign degen  = (pa0 == pa1) || (pb0 == pb1);

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [C-1:0] p0, p1, q0, q1, pmn, pmx, qmn, qmx;
    assign p0  = $signed(pa0[k*C +: C]);
    assign p1  = $signed(pa1[k*C +: C]);
    assign q0  = $signed(pb0[k*C +: C]);
    assign q1  = $signed(pb1[k*C +: C]);
    assign pmn = (p0 < p1) ? p0 : p1;
    assign pmx = (p0 > p1) ? p0 : p1;
    assign qmn = (q0 < q1) ? q0 : q1;
    assign qmx = (q0 > q1) ? q0 : q1;
    assign sep[k] = (EW'(qmx) + dr < EW'(pmn)) || (EW'(qmn) - dr > EW'(pmx));
  end

  assign item = {shared || (|sep) || degen, pb1, pb0, pa1, pa0};
endmodule
`default_nettype wire

### rtl/eepc_back.sv
// eepc_back: exact closest-distance pipeline, result queue and issue credits
// depends on eepc_pkg, eepc_umul and eepc_fifo
`timescale 1ns / 1ps
`default_nettype none
module eepc_back #(
  parameter int C = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [12*C:0]  mid_data,
  input  logic           mid_empty,
  output logic           mid_pop,
  input  logic [eepc_pkg::RADIUS_BITS-1:0] radius,
  input  logic           out_pop,
  output logic           out_empty,
  output logic           out_result
);
  import eepc_pkg::*;
  localparam int D   = C + 1;
  localparam int N   = 2 * D + 1;
  localparam int DW  = 2 * N + 2;
  localparam int WNW = D + N + 2;
  localparam int LW  = C + D + 2;
  localparam int RW  = LW + 2;
  localparam int VW  = 2 * D + 2;
  localparam int D2W = 2 * RADIUS_BITS;
  localparam int CNW = $clog2(OUT_DEPTH + 1);

  function automatic logic signed [N-1:0] crs(input logic signed [D-1:0] x, y, u, v);
    return N'(x) * N'(y) - N'(u) * N'(v);
  endfunction

  function automatic logic uratio(input logic signed [RW-1:0] num, den);
    logic nneg, npos;
    nneg = num[RW-1] || (num == '0);
    npos = !num[RW-1];
    if (den[RW-1]) begin
      return nneg && (num >= den);
    end else begin
      return npos && (num <= den);
    end
  endfunction

  // issue credits
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           issue, opop_acc, ofull, opush, res;

  assign issue    = !mid_empty && (cnt_r < CNW'(OUT_DEPTH));
  assign mid_pop  = issue;
  assign opop_acc = out_pop && !out_empty;
  assign cnt_nxt  = cnt_r + CNW'(issue) - CNW'(opop_acc);

  // stage 1: differences, cross products, projections and radius squared
  logic signed [C-1:0] p0 [3], p1 [3], q0 [3], q1 [3];
  logic signed [D-1:0] vp [3], vq [3], w [3];
  logic signed [N-1:0] n_c [3], cwq_c [3], cwp_c [3];
  logic signed [LW-1:0] lp0_c, lp1_c, lq0_c, lq1_c;
  logic signed [VW-1:0] vpvp_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0[k] = $signed(mid_data[k*C +: C]);
      p1[k] = $signed(mid_data[3*C + k*C +: C]);
      q0[k] = $signed(mid_data[6*C + k*C +: C]);
      q1[k] = $signed(mid_data[9*C + k*C +: C]);
      vp[k] = D'(p1[k]) - D'(p0[k]);
      vq[k] = D'(q1[k]) - D'(q0[k]);
      w[k]  = D'(q0[k]) - D'(p0[k]);
    end
    n_c[0]   = crs(vp[1], vq[2], vp[2], vq[1]);
    n_c[1]   = crs(vp[2], vq[0], vp[0], vq[2]);
    n_c[2]   = crs(vp[0], vq[1], vp[1], vq[0]);
    cwq_c[0] = crs(w[1], vq[2], w[2], vq[1]);
    cwq_c[1] = crs(w[2], vq[0], w[0], vq[2]);
    cwq_c[2] = crs(w[0], vq[1], w[1], vq[0]);
    cwp_c[0] = crs(w[1], vp[2], w[2], vp[1]);
    cwp_c[1] = crs(w[2], vp[0], w[0], vp[2]);
    cwp_c[2] = crs(w[0], vp[1], w[1], vp[0]);
    lp0_c = '0;
    lp1_c = '0;
    lq0_c = '0;
    lq1_c = '0;
    vpvp_c = '0;
    for (int k = 0; k < 3; k++) begin
      lp0_c  = lp0_c + LW'(p0[k]) * LW'(vp[k]);
      lp1_c  = lp1_c + LW'(p1[k]) * LW'(vp[k]);
      lq0_c  = lq0_c + LW'(q0[k]) * LW'(vp[k]);
      lq1_c  = lq1_c + LW'(q1[k]) * LW'(vp[k]);
      vpvp_c = vpvp_c + VW'(vp[k]) * VW'(vp[k]);
    end
  end

  logic                 v1_r;
  logic                 s1_rej;
  logic signed [N-1:0]  s1_n [3], s1_cwq [3], s1_cwp [3];
  logic signed [D-1:0]  s1_w [3];
  logic signed [LW-1:0] s1_lp0, s1_lp1, s1_lq0, s1_lq1;
  logic [VW-1:0]        s1_vpvp;
  logic [D2W-1:0]       s1_d2;

  always_ff @(posedge clk) begin
    s1_rej  <= mid_data[12*C];
    s1_n    <= n_c;
    s1_cwq  <= cwq_c;
    s1_cwp  <= cwp_c;
    s1_w    <= w;
    s1_lp0  <= lp0_c;
    s1_lp1  <= lp1_c;
    s1_lq0  <= lq0_c;
    s1_lq1  <= lq1_c;
    s1_vpvp <= vpvp_c;
    s1_d2   <= D2W'(radius) * D2W'(radius);
  end

  // stage 2: dot products and the parallel-edge midpoint test
  logic signed [DW-1:0]  det_c, sq_c, tp_c, cc_c;
  logic signed [WNW-1:0] wn_c;
  logic signed [LW-1:0]  pmn, pmx, qmn, qmx;
  logic signed [LW:0]    m2;
  logic                  par_ok_c;

  always_comb begin
    det_c = '0;
    sq_c  = '0;
    tp_c  = '0;
    cc_c  = '0;
    wn_c  = '0;
    for (int k = 0; k < 3; k++) begin
      det_c = det_c + DW'(s1_n[k]) * DW'(s1_n[k]);
      sq_c  = sq_c + DW'(s1_cwq[k]) * DW'(s1_n[k]);
      tp_c  = tp_c + DW'(s1_cwp[k]) * DW'(s1_n[k]);
      cc_c  = cc_c + DW'(s1_cwp[k]) * DW'(s1_cwp[k]);
      wn_c  = wn_c + WNW'(s1_w[k]) * WNW'(s1_n[k]);
    end
    pmn = (s1_lp0 < s1_lp1) ? s1_lp0 : s1_lp1;
    pmx = (s1_lp0 > s1_lp1) ? s1_lp0 : s1_lp1;
    qmn = (s1_lq0 < s1_lq1) ? s1_lq0 : s1_lq1;
    qmx = (s1_lq0 > s1_lq1) ? s1_lq0 : s1_lq1;
    if (pmx < qmn) begin
      m2 = (LW+1)'(pmx) + (LW+1)'(qmn);
    end else if (qmx < pmn) begin
      m2 = (LW+1)'(qmx) + (LW+1)'(pmn);
    end else if (pmx < qmx) begin
      m2 = (LW+1)'(pmx) + (LW+1)'(qmn);
    end else begin
      m2 = (LW+1)'(qmx) + (LW+1)'(pmn);
    end
    par_ok_c = uratio(RW'(m2) - RW'(s1_lp0) - RW'(s1_lp0),
                      RW'(s1_lp1) + RW'(s1_lp1) - RW'(s1_lp0) - RW'(s1_lp0)) &&
               uratio(RW'(m2) - RW'(s1_lq0) - RW'(s1_lq0),
                      RW'(s1_lq1) + RW'(s1_lq1) - RW'(s1_lq0) - RW'(s1_lq0));
  end

  logic                  v2_r, s2_rej, s2_par, s2_par_ok;
  logic signed [DW-1:0]  s2_det, s2_sq, s2_tp, s2_cc;
  logic signed [WNW-1:0] s2_wn;
  logic [VW-1:0]         s2_vpvp;
  logic [D2W-1:0]        s2_d2;

  always_ff @(posedge clk) begin
    s2_rej    <= s1_rej;
    s2_par    <= (s1_n[0] == '0) && (s1_n[1] == '0) && (s1_n[2] == '0);
    s2_par_ok <= par_ok_c;
    s2_det    <= det_c;
    s2_sq     <= sq_c;
    s2_tp     <= tp_c;
    s2_cc     <= cc_c;
    s2_wn     <= wn_c;
    s2_vpvp   <= s1_vpvp;
    s2_d2     <= s1_d2;
  end

  // stages 3 and 4: wide squared-distance products
  logic [WNW-1:0]     wn_abs;
  logic               sk_ok_c;
  logic [2*WNW-1:0]   wn2;
  logic [D2W+DW-1:0]  dd;
  logic [D2W+VW-1:0]  dv;

  assign wn_abs  = s2_wn[WNW-1] ? WNW'(-s2_wn) : WNW'(s2_wn);
  assign sk_ok_c = !s2_sq[DW-1] && (s2_sq <= s2_det) && !s2_tp[DW-1] && (s2_tp <= s2_det);

  eepc_umul #(.WA(WNW), .WB(WNW)) u_wn2 (.clk(clk), .a(wn_abs), .b(wn_abs), .p(wn2));
  eepc_umul #(.WA(D2W), .WB(DW)) u_dd (.clk(clk), .a(s2_d2), .b(DW'(s2_det)), .p(dd));
  eepc_umul #(.WA(D2W), .WB(VW)) u_dv (.clk(clk), .a(s2_d2), .b(s2_vpvp), .p(dv));

  logic              v3_r, s3_rej, s3_par, s3_par_ok, s3_sk_ok;
  logic              v4_r, s4_rej, s4_par, s4_par_ok, s4_sk_ok;
  logic [DW-1:0]     s3_cc, s4_cc;

  always_ff @(posedge clk) begin
    s3_rej    <= s2_rej;
    s3_par    <= s2_par;
    s3_par_ok <= s2_par_ok;
    s3_sk_ok  <= sk_ok_c;
    s3_cc     <= DW'(s2_cc);
    s4_rej    <= s3_rej;
    s4_par    <= s3_par;
    s4_par_ok <= s3_par_ok;
    s4_sk_ok  <= s3_sk_ok;
    s4_cc     <= s3_cc;
  end

  localparam int SW = (2*WNW > D2W+DW) ? 2*WNW : D2W+DW;
  localparam int PW = (DW > D2W+VW) ? DW : D2W+VW;

  assign res = !s4_rej &&
               (s4_par ? (s4_par_ok && (PW'(s4_cc) <= PW'(dv)))
                       : (s4_sk_ok && (SW'(wn2) <= SW'(dd))));
  assign opush = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      v1_r  <= issue;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
    end
  end

  eepc_fifo #(.WIDTH(1), .DEPTH(OUT_DEPTH)) u_outq (
    .clk(clk), .rst_n(rst_n), .push(opush), .wdata(res), .pop(out_pop),
    .rdata(out_result), .full(ofull), .empty(out_empty)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(OUT_DEPTH)) else $error("credit count above queue depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    opush |-> !ofull) else $error("result queue overflow");
  a_empty_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> out_empty) else $error("result without credit");
  a_issue_valid: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> v1_r) else $error("issue lost");
endmodule
`default_nettype wire

### rtl/edge_edge_proximity_contact_core.sv
// edge_edge_proximity_contact_core: top level of the edge-edge contact test
// depends on eepc_pkg, eepc_front, eepc_fifo and eepc_back
// an accepted input transaction passes the front queue, the registered back stages and the result queue
// throughput: one transaction per cycle while issue credits remain, set by the fully pipelined back datapath
// a 4-entry queue decouples front and back; an 8-entry result queue absorbs stalls
// reset: synchronous active-low, empties both queues and clears radius_r to 0
`timescale 1ns / 1ps
`default_nettype none
module edge_edge_proximity_contact_core #(
  parameter int COORD_BITS     = 16,
  parameter int VERTEX_ID_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [VERTEX_ID_BITS-1:0]   in_edge_a_vertex0,
  input  logic [VERTEX_ID_BITS-1:0]   in_edge_a_vertex1,
  input  logic [VERTEX_ID_BITS-1:0]   in_edge_b_vertex0,
  input  logic [VERTEX_ID_BITS-1:0]   in_edge_b_vertex1,
  input  logic [3*COORD_BITS-1:0]     in_edge_a_start,
  input  logic [3*COORD_BITS-1:0]     in_edge_a_end,
  input  logic [3*COORD_BITS-1:0]     in_edge_b_start,
  input  logic [3*COORD_BITS-1:0]     in_edge_b_end,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_in_contact,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [eepc_pkg::RADIUS_BITS-1:0] cfg_data
);
  import eepc_pkg::*;
  localparam int IW = 12 * COORD_BITS + 1;

  logic [RADIUS_BITS-1:0] radius_r;
  logic [IW-1:0]          item, mid_data;
  logic                   mid_full, mid_empty, mid_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_data;
    end
  end

  eepc_front #(.C(COORD_BITS), .VB(VERTEX_ID_BITS)) u_front (
    .a_v0(in_edge_a_vertex0), .a_v1(in_edge_a_vertex1),
    .b_v0(in_edge_b_vertex0), .b_v1(in_edge_b_vertex1),
    .pa0(in_edge_a_start), .pa1(in_edge_a_end),
    .pb0(in_edge_b_start), .pb1(in_edge_b_end),
    .radius(radius_r), .item(item)
  );

  assign in_full = mid_full;

  eepc_fifo #(.WIDTH(IW), .DEPTH(MID_DEPTH)) u_midq (
    .clk(clk), .rst_n(rst_n), .push(in_push), .wdata(item), .pop(mid_pop),
    .rdata(mid_data), .full(mid_full), .empty(mid_empty)
  );

  eepc_back #(.C(COORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .mid_data(mid_data), .mid_empty(mid_empty),
    .mid_pop(mid_pop), .radius(radius_r), .out_pop(out_pop),
    .out_empty(out_empty), .out_result(out_in_contact)
  );
endmodule
`default_nettype wire
